// ===== sv/asdd_pkg.sv =====
// ----------------------------------------------------------------------------
// asdd_pkg: shared types and constants of the scratch direction detector
// Widths, codes, fixed-point thresholds and the structs passed between units.
// ----------------------------------------------------------------------------
package asdd_pkg;

  localparam int unsigned AxisW    = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CntW     = 16;
  localparam int unsigned AccW     = 20;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // 0.9 of full scale in Q1.14, rounded up (0.9 * 16384 = 14745.6)
  localparam logic signed [AxisW-1:0] ThreshPos = 16'sd14746;
  localparam logic signed [AxisW-1:0] ThreshNeg = -16'sd14746;
  // one full scale step, at step width
  localparam logic signed [AxisW:0]   OneQ14    = 17'sd16384;
  localparam logic signed [AccW-1:0]  AccMax    = 20'sd524287;
  localparam logic signed [AccW-1:0]  AccMin    = -20'sd524288;

  localparam logic       ResetMode    = 1'b1;
  localparam logic [CntW-1:0] ResetSens    = 16'd1638;
  localparam logic [CntW-1:0] ResetTimeout = 16'd100;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } ev_e;

  typedef enum logic {
    MODE_CLASSIC = 1'b0,
    MODE_DELTA   = 1'b1
  } mode_e;

  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_TICK   = 1'b1
  } func_e;

  localparam logic [CfgIdxW-1:0] CfgIdxMode    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxSens    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxTimeout = 2'd2;

  typedef struct packed {
    mode_e            mode;
    logic [CntW-1:0]  sensitivity;
    logic [CntW-1:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    func_e                   func;
    logic signed [AxisW-1:0] axis_value;
    logic [TimeW-1:0]        event_time;
  } item_t;

  typedef struct packed {
    logic signed [AxisW-1:0] last_value;
    logic                    last_valid;
    logic signed [AccW-1:0]  acc;
    dir_e                    direction;
    logic [CntW-1:0]         countdown;
    logic [TimeW-1:0]        release_stamp;
    logic                    up_pressed;
    logic                    down_pressed;
  } state_t;

  typedef struct packed {
    logic             up_held;
    logic             down_held;
    ev_e              up_event;
    ev_e              down_event;
    logic [TimeW-1:0] stamp_out;
  } result_t;

endpackage

// ===== sv/asdd_in_if.sv =====
// ----------------------------------------------------------------------------
// asdd_in_if: input item channel
// Valid/ready channel carrying one axis sample or tick.
// ----------------------------------------------------------------------------
interface asdd_in_if;
  logic                              valid;
  logic                              ready;
  logic                              func;
  logic signed [asdd_pkg::AxisW-1:0] axis_value;
  logic [asdd_pkg::TimeW-1:0]        event_time;

  modport source (output valid, func, axis_value, event_time, input ready);
  modport sink   (input valid, func, axis_value, event_time, output ready);
endinterface

// ===== sv/asdd_out_if.sv =====
// ----------------------------------------------------------------------------
// asdd_out_if: result channel
// Valid/ready channel carrying button states, events and event time.
// ----------------------------------------------------------------------------
interface asdd_out_if;
  logic                       valid;
  logic                       ready;
  logic                       up_held;
  logic                       down_held;
  logic [1:0]                 up_event;
  logic [1:0]                 down_event;
  logic [asdd_pkg::TimeW-1:0] stamp_out;

  modport source (output valid, up_held, down_held, up_event, down_event, stamp_out,
                  input ready);
  modport sink   (input valid, up_held, down_held, up_event, down_event, stamp_out,
                  output ready);
endinterface

// ===== sv/asdd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// asdd_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface asdd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [asdd_pkg::CfgIdxW-1:0]  index;
  logic [asdd_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/asdd_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// asdd_cfg_regs: configuration register file
// Holds mode, sensitivity and timeout; writes beyond the list are dropped.
// ----------------------------------------------------------------------------
module asdd_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  asdd_cfg_if.sink        cfg_i,
  output asdd_pkg::cfg_t  cfg_o
);
  import asdd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgIdxMode:    cfg_d.mode          = mode_e'(cfg_i.data[0]);
        CfgIdxSens:    cfg_d.sensitivity   = cfg_i.data[CntW-1:0];
        CfgIdxTimeout: cfg_d.timeout_ticks = cfg_i.data[CntW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= mode_e'(ResetMode);
      cfg_q.sensitivity   <= ResetSens;
      cfg_q.timeout_ticks <= ResetTimeout;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/asdd_step.sv =====
// ----------------------------------------------------------------------------
// asdd_step: single item update
// Combinational next state and result for one sample or tick.
// ----------------------------------------------------------------------------
module asdd_step (
  input  asdd_pkg::state_t  state_i,
  input  asdd_pkg::cfg_t    cfg_i,
  input  asdd_pkg::item_t   item_i,
  output asdd_pkg::state_t  state_o,
  output asdd_pkg::result_t result_o
);
  import asdd_pkg::*;

  logic signed [AxisW-1:0] lv;
  logic signed [AxisW:0]   diff, fold_sum, step;
  logic signed [AccW:0]    acc_sum, acc_ext, acc_neg, sens_ext;
  logic signed [AccW-1:0]  acc_sat;
  logic [CntW-1:0]         cd_dec;
  logic [CntW-1:0]         cd_load;
  logic                    fire_up, fire_down;

  // first sample stands in as its own predecessor
  assign lv       = state_i.last_valid ? state_i.last_value : item_i.axis_value;
  assign diff     = {item_i.axis_value[AxisW-1], item_i.axis_value} - {lv[AxisW-1], lv};
  assign fold_sum = {item_i.axis_value[AxisW-1], item_i.axis_value} + {lv[AxisW-1], lv};
  assign step     = (diff > OneQ14 || diff < -OneQ14) ? fold_sum : diff;

  assign acc_sum = {state_i.acc[AccW-1], state_i.acc}
                 + {{(AccW-AxisW){step[AxisW]}}, step};

  always_comb begin
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_sat = acc_sum[AccW] ? AccMin : AccMax;
    end else begin
      acc_sat = acc_sum[AccW-1:0];
    end
  end

  assign acc_ext   = {acc_sat[AccW-1], acc_sat};
  assign acc_neg   = -acc_ext;
  assign sens_ext  = $signed({{(AccW+1-CntW){1'b0}}, cfg_i.sensitivity});
  assign fire_up   = (step > 0) && (acc_ext >= sens_ext);
  assign fire_down = (step < 0) && (acc_neg >= sens_ext);

  assign cd_dec  = state_i.countdown - CntW'(1);
  assign cd_load = (cfg_i.timeout_ticks == '0) ? CntW'(1) : cfg_i.timeout_ticks;

  always_comb begin
    logic do_apply;
    logic [TimeW-1:0] stamp;
    state_o  = state_i;
    do_apply = 1'b0;
    stamp    = item_i.event_time;
    result_o = '0;

    if (item_i.func == FUNC_TICK) begin
      if (state_i.countdown != '0) begin
        state_o.countdown = cd_dec;
        if (cd_dec == '0) begin
          state_o.direction = DIR_NONE;
          do_apply          = 1'b1;
          stamp             = state_i.release_stamp;
        end
      end
    end else begin
      state_o.last_valid = 1'b1;
      state_o.last_value = lv;
      if (cfg_i.mode == MODE_CLASSIC) begin
        priority if (item_i.axis_value >= ThreshPos) begin
          state_o.direction = DIR_UP;
        end else if (item_i.axis_value <= ThreshNeg) begin
          state_o.direction = DIR_DOWN;
        end else begin
          state_o.direction = DIR_NONE;
        end
        do_apply = 1'b1;
      end else if (item_i.axis_value != lv) begin
        state_o.last_value = item_i.axis_value;
        state_o.acc        = acc_sat;
        if (fire_up || fire_down) begin
          state_o.acc           = '0;
          state_o.direction     = fire_up ? DIR_UP : DIR_DOWN;
          state_o.countdown     = cd_load;
          state_o.release_stamp = item_i.event_time + {{(TimeW-CntW){1'b0}},
                                                       cfg_i.timeout_ticks};
          do_apply              = 1'b1;
        end
      end
    end

    // drive the buttons toward the new direction, reporting only real changes
    if (do_apply) begin
      unique case (state_o.direction)
        DIR_UP: begin
          if (state_i.down_pressed) result_o.down_event = EV_RELEASE;
          if (!state_i.up_pressed)  result_o.up_event   = EV_PRESS;
          state_o.down_pressed = 1'b0;
          state_o.up_pressed   = 1'b1;
        end
        DIR_DOWN: begin
          if (state_i.up_pressed)     result_o.up_event   = EV_RELEASE;
          if (!state_i.down_pressed)  result_o.down_event = EV_PRESS;
          state_o.up_pressed   = 1'b0;
          state_o.down_pressed = 1'b1;
        end
        default: begin
          if (state_i.up_pressed)   result_o.up_event   = EV_RELEASE;
          if (state_i.down_pressed) result_o.down_event = EV_RELEASE;
          state_o.up_pressed   = 1'b0;
          state_o.down_pressed = 1'b0;
        end
      endcase
    end

    result_o.up_held   = state_o.up_pressed;
    result_o.down_held = state_o.down_pressed;
    result_o.stamp_out = (result_o.up_event == EV_NONE && result_o.down_event == EV_NONE)
                       ? '0 : stamp;
  end

endmodule

// ===== sv/analog_scratch_direction_detector.sv =====
// ----------------------------------------------------------------------------
// analog_scratch_direction_detector: turntable axis to up/down buttons
// Input register, single-pass update logic and result register.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one item per transfer: an axis sample (func = 0) or a
//   one millisecond tick (func = 1). out_o returns exactly one result per
//   item: held states of both buttons, press/release events and the time
//   of those events (zero when there is no event).
//   cfg_i writes mode (index 0), sensitivity (1) and timeout in ticks (2);
//   it is always ready. Write it only while no item is in flight.
// Timing:
//   An item accepted into the input register passes the update logic and
//   lands in the result register once the result slot is free.
//   One item per cycle is sustained while out_o.ready stays high; the update
//   loop through the state registers is combinational (17-bit step, 21-bit
//   accumulate and compare, 32-bit stamp).
// Reset:
//   rst_ni clears all state, empties both registers and loads the register
//   defaults (delta mode, sensitivity 1638, timeout 100).
// Stall:
//   When out_o.ready is low the result holds and a full input register holds;
//   in_i.ready drops only once both stages are full.
// ----------------------------------------------------------------------------
module analog_scratch_direction_detector (
  input  logic       clk_i,
  input  logic       rst_ni,
  asdd_in_if.sink    in_i,
  asdd_out_if.source out_o,
  asdd_cfg_if.sink   cfg_i
);
  import asdd_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_vld_q;
  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    res_vld_q;
  logic    res_free;
  logic    advance;

  asdd_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  asdd_step u_step (
    .state_i  (state_q),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // the result slot frees when empty or taken this cycle
  assign res_free   = !res_vld_q || out_o.ready;
  assign advance    = item_vld_q && res_free;
  assign in_i.ready = !item_vld_q || res_free;

  // input register: hold while the item cannot advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      item_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.func       <= func_e'(in_i.func);
      item_q.axis_value <= in_i.axis_value;
      item_q.event_time <= in_i.event_time;
    end
  end

  // detector state: advance once per item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{last_value:    '0,
                   last_valid:    1'b0,
                   acc:           '0,
                   direction:     DIR_NONE,
                   countdown:     '0,
                   release_stamp: '0,
                   up_pressed:    1'b0,
                   down_pressed:  1'b0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_free) begin
      res_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid      = res_vld_q;
  assign out_o.up_held    = res_q.up_held;
  assign out_o.down_held  = res_q.down_held;
  assign out_o.up_event   = res_q.up_event;
  assign out_o.down_event = res_q.down_event;
  assign out_o.stamp_out  = res_q.stamp_out;

`ifndef NO_ASSERTIONS
  // both buttons are never held at once
  a_not_both_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_q.up_pressed && state_q.down_pressed))
    else $error("both buttons held");

  // held buttons follow the current direction
  a_dir_matches_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.direction == DIR_NONE) |-> (!state_q.up_pressed && !state_q.down_pressed))
    else $error("button held with no direction");

  a_up_matches_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.direction == DIR_UP) |-> state_q.up_pressed)
    else $error("up direction without up held");

  // a result without events carries no time
  a_quiet_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.up_event == EV_NONE && res_q.down_event == EV_NONE)
      |-> (res_q.stamp_out == '0))
    else $error("stamp on result without events");
`endif

endmodule
